// ===== rtl/core/mlrr_pkg.sv =====
// Shared constants and types for the multilevel round-robin scheduler.
// Used by the top level, the task memory, the checkers and the testbench; depends on nothing.
package mlrr_pkg;

  // default sizing
  localparam int unsigned DefMaxTasks = 64;
  localparam int unsigned DefMaxLevel = 3;

  // request codes
  localparam logic [1:0] ReqTick   = 2'd0;
  localparam logic [1:0] ReqCreate = 2'd1;
  localparam logic [1:0] ReqSleep  = 2'd2;
  localparam logic [1:0] ReqWakeup = 2'd3;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StRefused  = 2'd3;

  // field write enables of a task entry
  localparam int unsigned FldPrev  = 0;
  localparam int unsigned FldNext  = 1;
  localparam int unsigned FldPrio  = 2;
  localparam int unsigned FldAwake = 3;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [3:0] fld;
  } mem_ctl_t;

endpackage

// ===== rtl/core/mlrr_task_mem.sv =====
// Task entry memory: awake flag, level and both queue links per task.
// One port, per-field write enables, registered read data. Uses mlrr_pkg.
module mlrr_task_mem import mlrr_pkg::*; #(
  parameter int unsigned Depth = DefMaxTasks,
  parameter int unsigned IdW   = 7,
  parameter int unsigned LvlW  = 2,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             wawake_i,
  input  logic [LvlW-1:0]  wprio_i,
  input  logic [IdW-1:0]   wnext_i,
  input  logic [IdW-1:0]   wprev_i,
  output logic             rawake_o,
  output logic [LvlW-1:0]  rprio_o,
  output logic [IdW-1:0]   rnext_o,
  output logic [IdW-1:0]   rprev_o
);

  localparam int unsigned EntW = 1 + LvlW + 2 * IdW;

  logic [EntW-1:0] mem_q [Depth];
  logic [EntW-1:0] rd_q;

  // write selected fields
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      if (ctl_i.fld[FldPrev])  mem_q[addr_i][IdW-1:0]               <= wprev_i;
      if (ctl_i.fld[FldNext])  mem_q[addr_i][2*IdW-1:IdW]           <= wnext_i;
      if (ctl_i.fld[FldPrio])  mem_q[addr_i][2*IdW+LvlW-1:2*IdW]    <= wprio_i;
      if (ctl_i.fld[FldAwake]) mem_q[addr_i][EntW-1]                <= wawake_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rprev_o  = rd_q[IdW-1:0];
  assign rnext_o  = rd_q[2*IdW-1:IdW];
  assign rprio_o  = rd_q[2*IdW+LvlW-1:2*IdW];
  assign rawake_o = rd_q[EntW-1];

endmodule

// ===== rtl/core/multilevel_round_robin_scheduler.sv =====
// Multilevel round-robin scheduler: one linked FIFO run queue per level.
// A command that moves a task reads its entry, unlinks it from both neighbours,
// then marks it asleep or relinks it and its new neighbour in the task memory.
// One command at a time: a new start is taken in the cycle the result word shows
// on done_o, and no new command is taken while busy.
// After reset busy stays high while the two boot tasks are written.
module multilevel_round_robin_scheduler import mlrr_pkg::*; #(
  parameter int unsigned MaxTasks = DefMaxTasks,
  parameter int unsigned MaxLevel = DefMaxLevel,
  parameter int unsigned IdW      = $clog2(MaxTasks + 1),
  parameter int unsigned LvlW     = $clog2(MaxLevel + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type_i,
  input  logic [IdW-1:0]   task_id_i,
  input  logic signed [LvlW:0] wake_level_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LvlW-1:0]  cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [IdW-1:0]   running_id_o,
  output logic [LvlW-1:0]  current_prio_o,
  output logic             switched_o,
  output logic [IdW-1:0]   new_id_o
);

  localparam int unsigned LvlN  = MaxLevel + 1;
  localparam int unsigned AddrW = $clog2(MaxTasks);

  localparam logic [3:0] SInit0 = 4'd0;
  localparam logic [3:0] SInit1 = 4'd1;
  localparam logic [3:0] SIdle  = 4'd2;
  localparam logic [3:0] SEnt   = 4'd3;
  localparam logic [3:0] SUnlP  = 4'd4;
  localparam logic [3:0] SUnlN  = 4'd5;
  localparam logic [3:0] SSlp   = 4'd6;
  localparam logic [3:0] SPSelf = 4'd7;
  localparam logic [3:0] SPNb   = 4'd8;
  localparam logic [3:0] SFin   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;

  localparam logic [LvlW-1:0] TopLvl = LvlW'(MaxLevel);

  logic [3:0]      state_q, state_d;
  logic [IdW-1:0]  head_q [LvlN];
  logic [IdW-1:0]  head_d [LvlN];
  logic [IdW-1:0]  tail_q [LvlN];
  logic [IdW-1:0]  tail_d [LvlN];
  logic [LvlW-1:0] active_q, active_d;
  logic [IdW-1:0]  last_q, last_d;
  logic [LvlW-1:0] dflt_q;

  logic [1:0]      req_q, req_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [IdW-1:0]  before_q, before_d;
  logic [IdW-1:0]  ep_q, ep_d;
  logic [IdW-1:0]  en_q, en_d;
  logic [LvlW-1:0] elv_q, elv_d;
  logic [LvlW-1:0] tgt_q, tgt_d;
  logic            front_q, front_d;
  logic            seltop_q, seltop_d;
  logic            setact_q, setact_d;
  logic [1:0]      st_q, st_d;
  logic [IdW-1:0]  nid_q, nid_d;
  logic            keep_q;

  logic            done_q;
  logic [1:0]      status_q;
  logic [IdW-1:0]  cur_q;
  logic [LvlW-1:0] prio_q;
  logic            sw_q;
  logic [IdW-1:0]  newid_q;

  mem_ctl_t        mctl;
  logic [IdW-1:0]  maddr_id_c;
  logic [IdW-1:0]  maddr_m1;
  logic [AddrW-1:0] maddr;
  logic            mw_awake;
  logic [LvlW-1:0] mw_prio;
  logic [IdW-1:0]  mw_next;
  logic [IdW-1:0]  mw_prev;
  logic            mr_awake;
  logic [LvlW-1:0] mr_prio;
  logic [IdW-1:0]  mr_next;
  logic [IdW-1:0]  mr_prev;

  logic [LvlW-1:0] lvl_sel;
  logic [IdW-1:0]  hsel;
  logic [IdW-1:0]  tsel;
  logic [LvlN-1:0] nonempty;
  logic [LvlW-1:0] top_lvl;
  logic            other_ne;
  logic [LvlW-1:0] wl_raw;
  logic [LvlW-1:0] wl_sat;
  logic [LvlW-1:0] dflt_sat;
  logic [LvlW-1:0] wake_lv;
  logic            found;

  // level selected for the head/tail port this cycle
  always_comb begin
    unique case (state_q)
      SEnt:         lvl_sel = mr_prio;
      SUnlP, SUnlN: lvl_sel = elv_q;
      SPSelf, SPNb: lvl_sel = tgt_q;
      default:      lvl_sel = active_q;
    endcase
  end

  assign hsel = head_q[lvl_sel];
  assign tsel = tail_q[lvl_sel];

  // non-empty levels, highest one, others besides the entry's level
  always_comb begin
    top_lvl  = active_q;
    other_ne = 1'b0;
    for (int l = 0; l < LvlN; l++) begin
      nonempty[l] = head_q[l] != '0;
      if (nonempty[l]) top_lvl = LvlW'(l);
      if (nonempty[l] && LvlW'(l) != mr_prio) other_ne = 1'b1;
    end
  end

  assign wl_raw   = wake_level_i[LvlW-1:0];
  assign wl_sat   = (wl_raw > TopLvl) ? TopLvl : wl_raw;
  assign dflt_sat = (dflt_q > TopLvl) ? TopLvl : dflt_q;
  assign wake_lv  = tgt_q;
  assign found    = (task_id_i != '0) && (task_id_i <= last_q);

  assign maddr_m1 = maddr_id_c - 1'b1;
  assign maddr    = maddr_m1[AddrW-1:0];

  // command sequencer
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    active_d   = active_q;
    last_d     = last_q;
    req_d      = req_q;
    id_d       = id_q;
    before_d   = before_q;
    ep_d       = ep_q;
    en_d       = en_q;
    elv_d      = elv_q;
    tgt_d      = tgt_q;
    front_d    = front_q;
    seltop_d   = seltop_q;
    setact_d   = setact_q;
    st_d       = st_q;
    nid_d      = nid_q;
    mctl       = '0;
    maddr_id_c = id_q;
    mw_awake   = 1'b1;
    mw_prio    = '0;
    mw_next    = '0;
    mw_prev    = '0;

    unique case (state_q)
      SInit0: begin
        mctl.wr    = 1'b1;
        mctl.fld   = 4'hF;
        maddr_id_c = IdW'(1);
        mw_prio    = TopLvl;
        state_d    = SInit1;
      end
      SInit1: begin
        mctl.wr    = 1'b1;
        mctl.fld   = 4'hF;
        maddr_id_c = IdW'(2);
        state_d    = SIdle;
      end
      SIdle: begin
        if (start) begin
          req_d    = req_type_i;
          before_d = hsel;
          seltop_d = 1'b0;
          setact_d = 1'b0;
          front_d  = 1'b0;
          st_d     = StOk;
          nid_d    = '0;
          tgt_d    = wake_level_i[LvlW] ? active_q : wl_sat;
          unique case (req_type_i)
            ReqTick: begin
              id_d     = hsel;
              tgt_d    = active_q;
              seltop_d = 1'b1;
              if (hsel == '0) begin
                state_d = SFin;
              end else begin
                mctl.rd    = 1'b1;
                maddr_id_c = hsel;
                state_d    = SEnt;
              end
            end
            ReqCreate: begin
              if (last_q >= IdW'(MaxTasks)) begin
                st_d = StFull;
              end else begin
                mctl.wr    = 1'b1;
                mctl.fld   = 4'hF;
                maddr_id_c = last_q + 1'b1;
                mw_awake   = 1'b0;
                mw_prio    = dflt_sat;
                last_d     = last_q + 1'b1;
                nid_d      = last_q + 1'b1;
              end
              state_d = SFin;
            end
            default: begin
              id_d = task_id_i;
              if (!found) begin
                st_d    = StNotFound;
                state_d = SFin;
              end else begin
                mctl.rd    = 1'b1;
                maddr_id_c = task_id_i;
                state_d    = SEnt;
              end
            end
          endcase
        end
      end
      SEnt: begin
        ep_d  = mr_prev;
        en_d  = mr_next;
        elv_d = mr_prio;
        unique case (req_q)
          ReqTick: state_d = SUnlP;
          ReqSleep: begin
            if (!mr_awake) begin
              state_d = SFin;
            end else if (hsel == id_q && tsel == id_q && !other_ne) begin
              st_d    = StRefused;
              state_d = SFin;
            end else begin
              seltop_d = before_q == id_q;
              state_d  = SUnlP;
            end
          end
          ReqWakeup: begin
            // keep the stored level when the wake level is negative
            tgt_d = (req_q == ReqWakeup && keep_q) ? mr_prio : tgt_q;
            if (!mr_awake) begin
              state_d = SPSelf;
            end else if (!keep_q && tgt_q != mr_prio) begin
              front_d  = before_q == id_q;
              setact_d = before_q == id_q;
              state_d  = SUnlP;
            end else begin
              state_d = SFin;
            end
          end
          default: state_d = SFin;
        endcase
      end
      SUnlP: begin
        // bypass the entry ahead, or move the head
        if (ep_q != '0) begin
          mctl.wr       = 1'b1;
          mctl.fld[FldNext] = 1'b1;
          maddr_id_c    = ep_q;
          mw_next       = en_q;
        end else begin
          head_d[elv_q] = en_q;
        end
        state_d = SUnlN;
      end
      SUnlN: begin
        if (en_q != '0) begin
          mctl.wr       = 1'b1;
          mctl.fld[FldPrev] = 1'b1;
          maddr_id_c    = en_q;
          mw_prev       = ep_q;
        end else begin
          tail_d[elv_q] = ep_q;
        end
        state_d = (req_q == ReqSleep) ? SSlp : SPSelf;
      end
      SSlp: begin
        mctl.wr            = 1'b1;
        mctl.fld[FldAwake] = 1'b1;
        mw_awake           = 1'b0;
        state_d            = SFin;
      end
      SPSelf: begin
        mctl.wr  = 1'b1;
        mctl.fld = 4'hF;
        mw_prio  = wake_lv;
        mw_next  = front_q ? hsel : '0;
        mw_prev  = front_q ? '0 : tsel;
        state_d  = SPNb;
      end
      SPNb: begin
        if (front_q) begin
          if (hsel != '0) begin
            mctl.wr           = 1'b1;
            mctl.fld[FldPrev] = 1'b1;
            maddr_id_c        = hsel;
            mw_prev           = id_q;
          end else begin
            tail_d[tgt_q] = id_q;
          end
          head_d[tgt_q] = id_q;
        end else begin
          if (tsel != '0) begin
            mctl.wr           = 1'b1;
            mctl.fld[FldNext] = 1'b1;
            maddr_id_c        = tsel;
            mw_next           = id_q;
          end else begin
            head_d[tgt_q] = id_q;
          end
          tail_d[tgt_q] = id_q;
        end
        state_d = SFin;
      end
      SFin: begin
        if (setact_q) begin
          active_d = tgt_q;
        end else if (seltop_q && (nonempty != '0)) begin
          active_d = top_lvl;
        end
        state_d = SOut;
      end
      SOut: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // wake level sign, held with the command
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start) begin
      keep_q <= wake_level_i[LvlW];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SInit0;
      active_q <= TopLvl;
      last_q   <= IdW'(2);
      dflt_q   <= LvlW'(1);
      done_q   <= 1'b0;
      for (int unsigned l = 0; l < LvlN; l++) begin
        head_q[l] <= (l == MaxLevel) ? IdW'(1) : (l == 0) ? IdW'(2) : '0;
        tail_q[l] <= (l == MaxLevel) ? IdW'(1) : (l == 0) ? IdW'(2) : '0;
      end
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      last_q   <= last_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      done_q   <= state_q == SOut;
      if (cfg_valid_i && cfg_ready_o) dflt_q <= cfg_data_i;
    end
  end

  // command payload and result word
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    before_q <= before_d;
    ep_q     <= ep_d;
    en_q     <= en_d;
    elv_q    <= elv_d;
    tgt_q    <= tgt_d;
    front_q  <= front_d;
    seltop_q <= seltop_d;
    setact_q <= setact_d;
    st_q     <= st_d;
    nid_q    <= nid_d;
    if (state_q == SOut) begin
      status_q <= st_q;
      cur_q    <= hsel;
      prio_q   <= active_q;
      sw_q     <= hsel != before_q;
      newid_q  <= nid_q;
    end
  end

  mlrr_task_mem #(
    .Depth (MaxTasks),
    .IdW   (IdW),
    .LvlW  (LvlW),
    .AddrW (AddrW)
  ) u_task_mem (
    .clk_i    (clk_i),
    .ctl_i    (mctl),
    .addr_i   (maddr),
    .wawake_i (mw_awake),
    .wprio_i  (mw_prio),
    .wnext_i  (mw_next),
    .wprev_i  (mw_prev),
    .rawake_o (mr_awake),
    .rprio_o  (mr_prio),
    .rnext_o  (mr_next),
    .rprev_o  (mr_prev)
  );

  assign busy           = state_q != SIdle;
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign running_id_o   = cur_q;
  assign current_prio_o = prio_q;
  assign switched_o     = sw_q;
  assign new_id_o       = newid_q;

endmodule

// ===== rtl/core/mlrr_checker.sv =====
// Port-level checks on the scheduler's command and result words.
// Bound to multilevel_round_robin_scheduler; uses mlrr_pkg for status codes.
module mlrr_props import mlrr_pkg::*; #(
  parameter int unsigned IdW  = 7,
  parameter int unsigned LvlW = 2
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [1:0]      status_o,
  input logic            switched_o,
  input logic [IdW-1:0]  new_id_o
);

  // an accepted command occupies the block
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("command not taken up");

  // a result word comes only as the block frees up
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy)) else $error("result word out of sequence");

  // a freshly created task leaves the running task alone
  a_create_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && new_id_o != '0 |-> status_o == StOk && !switched_o)
    else $error("create word inconsistent");

  // a result word is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

endmodule

bind multilevel_round_robin_scheduler mlrr_props #(.IdW(IdW), .LvlW(LvlW)) u_mlrr_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .switched_o (switched_o),
  .new_id_o   (new_id_o)
);

// ===== dv/mlrr_checker.sv =====
// Checker for the multilevel round-robin scheduler: watches commands, config
// writes and result words, predicts each result and compares field by field.
// Depends on mlrr_pkg for request and status codes.
`timescale 1ns / 100ps
module mlrr_checker import mlrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [6:0] task_id_i,
  input  logic [2:0] wake_level_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       done_o,
  input  logic [1:0] status_o,
  input  logic [6:0] running_id_o,
  input  logic [1:0] current_prio_o,
  input  logic       switched_o,
  input  logic [6:0] new_id_o,
  output int         fail_count,
  output int         pending_count,
  output int         word_count
);

  localparam int NTasks = 64;
  localparam int TopLvl = 3;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] cur_task;
    logic [1:0] cur_prio;
    logic       switched;
    logic [6:0] new_id;
  } sched_word_t;

  // scheduler state mirror, index by id (entry 0 unused)
  logic       awake [0:NTasks];
  logic [1:0] prio  [0:NTasks];
  logic [6:0] nxt   [0:NTasks];
  logic [6:0] prv   [0:NTasks];
  logic [6:0] head  [0:TopLvl];
  logic [6:0] tail  [0:TopLvl];
  logic [1:0] act_lvl;
  logic [6:0] top_id;
  logic [1:0] dflt_lvl;
  sched_word_t sched_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void unlink(input logic [6:0] id);
    logic [1:0] lv;
    logic [6:0] p, n;
    lv = prio[id]; p = prv[id]; n = nxt[id];
    if (p != 0) nxt[p] = n; else head[lv] = n;
    if (n != 0) prv[n] = p; else tail[lv] = p;
    nxt[id] = 0; prv[id] = 0;
  endfunction

  function automatic void link_tail(input logic [6:0] id, input logic [1:0] lv);
    logic [6:0] t;
    t = tail[lv];
    prio[id] = lv; prv[id] = t; nxt[id] = 0;
    if (t != 0) nxt[t] = id; else head[lv] = id;
    tail[lv] = id;
  endfunction

  function automatic void link_head(input logic [6:0] id, input logic [1:0] lv);
    logic [6:0] h;
    h = head[lv];
    prio[id] = lv; nxt[id] = h; prv[id] = 0;
    if (h != 0) prv[h] = id; else tail[lv] = id;
    head[lv] = id;
  endfunction

  function automatic void pick_top();
    for (int lv = TopLvl; lv >= 0; lv--) begin
      if (head[lv] != 0) begin
        act_lvl = lv[1:0];
        return;
      end
    end
  endfunction

  function automatic bit lone_runnable(input logic [6:0] id);
    logic [1:0] p;
    p = prio[id];
    if (head[p] != id || tail[p] != id) return 0;
    for (int lv = 0; lv <= TopLvl; lv++)
      if (lv != p && head[lv] != 0) return 0;
    return 1;
  endfunction

  function automatic void reset_state();
    for (int i = 0; i <= NTasks; i++) begin
      awake[i] = 0; prio[i] = 0; nxt[i] = 0; prv[i] = 0;
    end
    for (int l = 0; l <= TopLvl; l++) begin
      head[l] = 0; tail[l] = 0;
    end
    awake[1] = 1; awake[2] = 1;
    link_tail(7'd1, 2'(TopLvl));
    link_tail(7'd2, 2'd0);
    act_lvl = 2'(TopLvl);
    top_id = 7'd2;
    dflt_lvl = 2'd1;
  endfunction

  // apply one command to the mirror and return the expected result word
  function automatic sched_word_t schedule(input logic [1:0] req, input logic [6:0] id,
                                           input logic [2:0] wl);
    sched_word_t w;
    logic [6:0] was, cur;
    logic [1:0] old, lv;
    bit keep, found, is_cur;
    w = '0;
    keep = wl[2];
    was = head[act_lvl];
    found = id >= 1 && id <= top_id;
    w.status = StOk;
    if (req == ReqTick) begin
      cur = head[act_lvl];
      if (cur != 0) begin
        unlink(cur);
        link_tail(cur, act_lvl);
      end
      pick_top();
    end else if (req == ReqCreate) begin
      if (top_id >= NTasks) begin
        w.status = StFull;
      end else begin
        top_id++;
        awake[top_id] = 0; prio[top_id] = dflt_lvl;
        nxt[top_id] = 0; prv[top_id] = 0;
        w.new_id = top_id;
      end
    end else if (!found) begin
      w.status = StNotFound;
    end else if (req == ReqSleep) begin
      if (awake[id]) begin
        if (lone_runnable(id)) begin
          w.status = StRefused;
        end else begin
          is_cur = head[act_lvl] == id;
          unlink(id);
          awake[id] = 0;
          if (is_cur) pick_top();
        end
      end
    end else begin
      old = prio[id];
      lv = keep ? old : (wl > 3'd3 ? 2'(TopLvl) : wl[1:0]);
      if (!awake[id]) begin
        awake[id] = 1;
        link_tail(id, lv);
      end else if (!keep && lv != old) begin
        if (head[act_lvl] != id) begin
          unlink(id);
          link_tail(id, lv);
        end else begin
          unlink(id);
          link_head(id, lv);
          act_lvl = lv;
        end
      end
    end
    w.cur_task = head[act_lvl];
    w.cur_prio = act_lvl;
    w.switched = head[act_lvl] != was;
    return w;
  endfunction

  // predict on accepted commands, compare each result word
  always @(posedge clk_i) begin
    sched_word_t got, want;
    if (!rst_ni) begin
      fail_count = 0;
      word_count = 0;
      sched_q.delete();
      reset_state();
    end else begin
      if (done_o) begin
        got = '{status_o, running_id_o, current_prio_o, switched_o, new_id_o};
        word_count++;
        if (sched_q.size() == 0) begin
          report_mismatch("unexpected word, status", got.status, 0);
        end else begin
          want = sched_q[0];
          sched_q.delete(0);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.cur_task != want.cur_task)
            report_mismatch("running id", got.cur_task, want.cur_task);
          if (got.cur_prio != want.cur_prio)
            report_mismatch("current_prio", got.cur_prio, want.cur_prio);
          if (got.switched != want.switched)
            report_mismatch("switched", got.switched, want.switched);
          if (got.new_id != want.new_id) report_mismatch("new_id", got.new_id, want.new_id);
        end
      end
      if (start && !busy) sched_q = {sched_q, schedule(req_type_i, task_id_i, wake_level_i)};
      if (cfg_valid_i && cfg_ready_o) dflt_lvl = cfg_data_i;
    end
    pending_count = sched_q.size();
  end

endmodule

// ===== dv/tb_multilevel_round_robin_scheduler.sv =====
// Testbench top for the multilevel round-robin scheduler: drives commands and
// default-level writes with random gaps, instantiates the block and mlrr_checker.
`timescale 1ns / 100ps
module tb_multilevel_round_robin_scheduler import mlrr_pkg::*;;

  localparam int RandItems = 1850;
  localparam int CycleLimit = 400000;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       start = 0;
  logic       busy;
  logic [1:0] req_type_i = ReqTick;
  logic [6:0] task_id_i = '0;
  logic [2:0] wake_level_i = '0;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;
  logic       done_o;
  logic [1:0] status_o;
  logic [6:0] running_id_o;
  logic [1:0] current_prio_o;
  logic       switched_o;
  logic [6:0] new_id_o;
  int         fail_count, pending_count, word_count;
  int         cycles = 0;
  int         sent = 0;

  always #5 clk_i = ~clk_i;

  multilevel_round_robin_scheduler u_top (.*);

  mlrr_checker u_chk (.*);

  // hard stop on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n < 5) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) @(posedge clk_i);
  endtask

  // hand one command word over and hold until accepted
  task automatic send(input logic [1:0] req, input logic [6:0] id, input logic [2:0] wl);
    start <= 1;
    req_type_i <= req;
    task_id_i <= id;
    wake_level_i <= wl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 0;
    sent++;
    @(posedge clk_i);
    random_gap();
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_default(input logic [1:0] lv);
    cfg_valid_i <= 1;
    cfg_data_i <= lv;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [2:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 3'b111;
    if (r < 3) return 3'($urandom_range(4, 7));
    return 3'($urandom_range(0, 3));
  endfunction

  initial begin
    int r;
    logic [6:0] id;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: bad ids, refusal, sleep of current, every wakeup flavour
    write_default(2'd0);
    send(ReqSleep, 7'd0, 3'd0);
    send(ReqWakeup, 7'd3, 3'd0);
    send(ReqSleep, 7'd127, 3'd0);
    send(ReqTick, 7'd0, 3'd0);
    send(ReqSleep, 7'd1, 3'd0);
    send(ReqSleep, 7'd2, 3'd0);
    send(ReqSleep, 7'd1, 3'd0);
    send(ReqCreate, 7'd0, 3'd0);
    send(ReqWakeup, 7'd3, 3'b111);
    send(ReqWakeup, 7'd1, 3'd5);
    send(ReqWakeup, 7'd1, 3'd3);
    send(ReqWakeup, 7'd3, 3'd3);
    send(ReqWakeup, 7'd3, 3'b111);
    send(ReqTick, 7'd0, 3'd0);
    send(ReqWakeup, 7'd1, 3'd1);
    send(ReqWakeup, 7'd2, 3'd2);
    send(ReqSleep, 7'd1, 3'd0);
    send(ReqWakeup, 7'd1, 3'b111);
    drain();
    write_default(2'd3);

    // random: mostly valid ids, create until full, level changes between phases
    for (int i = 0; i < RandItems; i++) begin
      if (i % 400 == 399) begin
        drain();
        write_default(2'($urandom_range(0, 3)));
      end
      r = $urandom_range(0, 99);
      id = 7'($urandom_range(1, 64));
      if ($urandom_range(0, 19) == 0) id = 7'($urandom_range(0, 127));
      if (r < 30) send(ReqTick, 7'($urandom), 3'($urandom));
      else if (r < 42) send(ReqCreate, 7'($urandom), 3'($urandom));
      else if (r < 65) send(ReqSleep, id, 3'($urandom));
      else send(ReqWakeup, id, rand_level());
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands, %0d result words checked, default level swept.",
             sent, word_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mlrr_pkg.sv
rtl/core/mlrr_task_mem.sv
rtl/core/multilevel_round_robin_scheduler.sv
rtl/core/mlrr_checker.sv
dv/mlrr_checker.sv
dv/tb_multilevel_round_robin_scheduler.sv
